// File: design/bctd_pkg.sv
// Shared types, codes and divide-by-constant helpers for the BC1-BC5 block decoder.
package bctd_pkg;

  localparam int unsigned DEFAULT_MAX_SIDE = 16384;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int FMT_W = 3;
  localparam int DIM_W = 15;
  localparam int BPOS_W = 12;
  localparam int PIX_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [FMT_W-1:0] FMT_BC1 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BC2 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BC3 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BC4 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BC5 = 3'd4;

  localparam logic [FMT_W-1:0] RESET_FORMAT = FMT_BC1;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 15'd4;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 15'd4;

  // Alpha ramp operation after the numerator stage
  localparam logic [1:0] RAMP_DIRECT = 2'd0;
  localparam logic [1:0] RAMP_DIV7   = 2'd1;
  localparam logic [1:0] RAMP_DIV5   = 2'd2;

  typedef struct packed {
    logic [7:0] a0;
    logic [7:0] a1;
    logic [2:0] k;
  } ramp_t;

  // One texel slot as issued by the sequencer
  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] fmt;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [15:0]      c0;
    logic [15:0]      c1;
    logic [1:0]       cidx;
    logic [3:0]       nib;
    ramp_t            ra;
    ramp_t            rb;
  } texel_t;

  // Numerators ready for the divide stage
  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] fmt;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [2:0][9:0]  cnum;
    logic [2:0]       cdiv;
    logic [10:0]      anum;
    logic [1:0]       aop;
    logic [10:0]      bnum;
    logic [1:0]       bop;
    logic [7:0]       nib_alpha;
  } numer_t;

  // floor(x/3) for x <= 767
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // floor(x/7) for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5) for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage

// File: design/bctd_seq.sv
// Block holding register and texel sequencer: issues one texel slot per cycle while adv_i is high.
module bctd_seq #(
  parameter int unsigned MAX_IMAGE_SIDE = bctd_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   block_first_word_i,
  input  logic [63:0]                   block_second_word_i,
  input  logic [bctd_pkg::BPOS_W-1:0]   block_column_i,
  input  logic [bctd_pkg::BPOS_W-1:0]   block_row_i,
  input  logic [bctd_pkg::FMT_W-1:0]    fmt_i,
  input  logic [bctd_pkg::DIM_W-1:0]    width_i,
  input  logic [bctd_pkg::DIM_W-1:0]    height_i,
  input  logic                          adv_i,
  output logic                          slot_valid_o,
  output bctd_pkg::texel_t              slot_o
);

  localparam int SIDE_W = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int LIM_W = (SIDE_W > bctd_pkg::DIM_W) ? SIDE_W : bctd_pkg::DIM_W;
  localparam logic [LIM_W-1:0] SideMax = LIM_W'(MAX_IMAGE_SIDE);

  logic                         busy_q, busy_d;
  logic [3:0]                   n_q, n_d;
  logic [15:0]                  mask_q, mask_d;
  logic [63:0]                  w0_q, w1_q;
  logic [bctd_pkg::BPOS_W-1:0]  col_q, row_q;
  logic [bctd_pkg::FMT_W-1:0]   fmt_q;

  logic [LIM_W-1:0] wlim, hlim, wext, hext;
  logic [3:0]       col_ok, row_ok;
  logic             fmt_ok, load, done;
  logic [15:0]      rest;
  logic [63:0]      cw;
  logic [31:0]      cbits;
  logic [63:0]      nibs;
  logic [47:0]      codes_a, codes_b;

  always_comb begin
    wext = LIM_W'(width_i);
    hext = LIM_W'(height_i);
    wlim = (wext < SideMax) ? wext : SideMax;
    hlim = (hext < SideMax) ? hext : SideMax;
    for (int i = 0; i < 4; i++) begin
      col_ok[i] = LIM_W'({block_column_i, 2'(i)}) < wlim;
      row_ok[i] = LIM_W'({block_row_i, 2'(i)}) < hlim;
    end
    fmt_ok = (fmt_i <= bctd_pkg::FMT_BC5);
    for (int n = 0; n < 16; n++) begin
      mask_d[n] = fmt_ok & col_ok[n % 4] & row_ok[n / 4];
    end
  end

  // Current slot is the block's final one when no in-image texel lies above it
  assign rest = mask_q >> n_q;
  assign done = (rest[15:1] == 15'd0);
  assign in_stall_o = busy_q & ~(adv_i & done);
  assign load = in_valid_i & ~in_stall_o;

  always_comb begin
    busy_d = busy_q;
    n_d = n_q;
    if (busy_q && adv_i) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        n_d = n_q + 4'd1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      n_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q <= mask_d;
      w0_q <= block_first_word_i;
      w1_q <= block_second_word_i;
      col_q <= block_column_i;
      row_q <= block_row_i;
      fmt_q <= fmt_i;
    end
  end

  always_comb begin
    cw = (fmt_q == bctd_pkg::FMT_BC1) ? w0_q : w1_q;
    cbits = cw[63:32] >> {n_q, 1'b0};
    nibs = w0_q >> {n_q, 2'b00};
    codes_a = w0_q[63:16] >> (6'(n_q) * 6'd3);
    codes_b = w1_q[63:16] >> (6'(n_q) * 6'd3);

    slot_valid_o = busy_q & rest[0];
    slot_o.last = done;
    slot_o.fmt = fmt_q;
    slot_o.px = {col_q, n_q[1:0]};
    slot_o.py = {row_q, n_q[3:2]};
    slot_o.c0 = cw[15:0];
    slot_o.c1 = cw[31:16];
    slot_o.cidx = cbits[1:0];
    slot_o.nib = nibs[3:0];
    slot_o.ra.a0 = w0_q[7:0];
    slot_o.ra.a1 = w0_q[15:8];
    slot_o.ra.k = codes_a[2:0];
    slot_o.rb.a0 = w1_q[7:0];
    slot_o.rb.a1 = w1_q[15:8];
    slot_o.rb.k = codes_b[2:0];
  end

endmodule

// File: design/bctd_decode.sv
// Three-stage texel decode pipeline: capture, numerators, divide and channel select.
module bctd_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        slot_valid_i,
  input  bctd_pkg::texel_t            slot_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bctd_pkg::PIX_W-1:0]  pixel_x_o,
  output logic [bctd_pkg::PIX_W-1:0]  pixel_y_o,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic [7:0]                  alpha_o,
  output logic                        last_texel_o
);

  logic             v1_q, v2_q, v3_q;
  bctd_pkg::texel_t s1_q;
  bctd_pkg::numer_t s2_q, s2_d;
  logic [bctd_pkg::PIX_W-1:0] px3_q, py3_q;
  logic [7:0]       r3_q, g3_q, b3_q, a3_q, r3_d, g3_d, b3_d, a3_d;
  logic             last3_q;

  // Hold every stage while the output item waits
  assign adv_o = ~(v3_q & out_stall_i);

  function automatic logic [7:0] expand(input logic [15:0] c, input int ch);
    logic [7:0] e;
    case (ch)
      0: e = {c[15:11], 3'b000};
      1: e = {c[10:5], 2'b00};
      default: e = {c[4:0], 3'b000};
    endcase
    return e;
  endfunction

  function automatic logic [12:0] ramp_num(input bctd_pkg::ramp_t r);
    logic [2:0]  wa, wb;
    logic [10:0] num;
    logic [1:0]  op;
    wa = (r.a0 > r.a1) ? (3'd0 - r.k) : (3'd6 - r.k);
    wb = r.k - 3'd1;
    num = 11'(wa) * 11'(r.a0) + 11'(wb) * 11'(r.a1);
    op = (r.a0 > r.a1) ? bctd_pkg::RAMP_DIV7 : bctd_pkg::RAMP_DIV5;
    if (r.k == 3'd0) begin
      num = 11'(r.a0);
      op = bctd_pkg::RAMP_DIRECT;
    end else if (r.k == 3'd1) begin
      num = 11'(r.a1);
      op = bctd_pkg::RAMP_DIRECT;
    end else if (r.a0 <= r.a1 && r.k == 3'd6) begin
      num = 11'd0;
      op = bctd_pkg::RAMP_DIRECT;
    end else if (r.a0 <= r.a1 && r.k == 3'd7) begin
      num = 11'd255;
      op = bctd_pkg::RAMP_DIRECT;
    end
    return {op, num};
  endfunction

  function automatic logic [7:0] ramp_div(input logic [10:0] num, input logic [1:0] op);
    logic [7:0] v;
    case (op)
      bctd_pkg::RAMP_DIV7: v = bctd_pkg::div7(num);
      bctd_pkg::RAMP_DIV5: v = bctd_pkg::div5(num);
      default: v = num[7:0];
    endcase
    return v;
  endfunction

  // Stage 2 input: endpoint expansion and numerators
  always_comb begin
    logic [7:0]  e0, e1;
    logic        three;
    logic [12:0] ra, rb;
    three = (s1_q.fmt == bctd_pkg::FMT_BC1) && (s1_q.c0 <= s1_q.c1);
    s2_d.last = s1_q.last;
    s2_d.fmt = s1_q.fmt;
    s2_d.px = s1_q.px;
    s2_d.py = s1_q.py;
    for (int ch = 0; ch < 3; ch++) begin
      e0 = expand(s1_q.c0, ch);
      e1 = expand(s1_q.c1, ch);
      s2_d.cdiv[ch] = 1'b0;
      case (s1_q.cidx)
        2'd0: s2_d.cnum[ch] = 10'(e0);
        2'd1: s2_d.cnum[ch] = 10'(e1);
        2'd2: begin
          if (three) begin
            s2_d.cnum[ch] = (10'(e0) + 10'(e1) + 10'd1) >> 1;
          end else begin
            s2_d.cnum[ch] = {1'b0, e0, 1'b0} + 10'(e1) + 10'd1;
            s2_d.cdiv[ch] = 1'b1;
          end
        end
        default: begin
          if (three) begin
            s2_d.cnum[ch] = 10'd0;
          end else begin
            s2_d.cnum[ch] = 10'(e0) + {1'b0, e1, 1'b0} + 10'd1;
            s2_d.cdiv[ch] = 1'b1;
          end
        end
      endcase
    end
    ra = ramp_num(s1_q.ra);
    rb = ramp_num(s1_q.rb);
    s2_d.anum = ra[10:0];
    s2_d.aop = ra[12:11];
    s2_d.bnum = rb[10:0];
    s2_d.bop = rb[12:11];
    s2_d.nib_alpha = {s1_q.nib, s1_q.nib};
  end

  // Stage 3 input: divide and route channels by format
  always_comb begin
    logic [2:0][7:0] rgb;
    logic [7:0]      ava, bva;
    for (int ch = 0; ch < 3; ch++) begin
      rgb[ch] = s2_q.cdiv[ch] ? bctd_pkg::div3(s2_q.cnum[ch]) : s2_q.cnum[ch][7:0];
    end
    ava = ramp_div(s2_q.anum, s2_q.aop);
    bva = ramp_div(s2_q.bnum, s2_q.bop);
    r3_d = rgb[0];
    g3_d = rgb[1];
    b3_d = rgb[2];
    a3_d = 8'd255;
    case (s2_q.fmt)
      bctd_pkg::FMT_BC1: a3_d = 8'd255;
      bctd_pkg::FMT_BC2: a3_d = s2_q.nib_alpha;
      bctd_pkg::FMT_BC3: a3_d = ava;
      bctd_pkg::FMT_BC4: begin
        r3_d = ava;
        g3_d = 8'd0;
        b3_d = 8'd0;
      end
      bctd_pkg::FMT_BC5: begin
        r3_d = bva;
        g3_d = ava;
        b3_d = 8'd0;
      end
      default: begin
        r3_d = 8'd0;
        g3_d = 8'd0;
        b3_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_o) begin
      v1_q <= slot_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_q <= slot_i;
      s2_q <= s2_d;
      px3_q <= s2_q.px;
      py3_q <= s2_q.py;
      r3_q <= r3_d;
      g3_q <= g3_d;
      b3_q <= b3_d;
      a3_q <= a3_d;
      last3_q <= s2_q.last;
    end
  end

  assign out_valid_o = v3_q;
  assign pixel_x_o = px3_q;
  assign pixel_y_o = py3_q;
  assign red_o = r3_q;
  assign green_o = g3_q;
  assign blue_o = b3_q;
  assign alpha_o = a3_q;
  assign last_texel_o = last3_q;

endmodule

// File: design/bc_texture_block_decoder.sv
// Top level of the BC1-BC5 block decoder: configuration registers and pipeline.
// Each accepted item is one compressed 4x4 block; it yields its in-image texels in
// row order, with last_texel_o set on the final one. A block occupies the texel
// sequencer from its first slot up to its last in-image texel (all sixteen slots
// for a block wholly inside the image, fewer at the right or bottom edge, only the
// first slot when nothing is emitted), and the next block is accepted in the cycle
// the current block's last slot issues, so blocks stream with no gap. Texels pass
// the capture, numerator and divide registers; a stall on the output holds the whole
// pipeline in place. Write configuration only while the decoder is idle.
module bc_texture_block_decoder #(
  parameter int unsigned MAX_IMAGE_SIDE = bctd_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bctd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bctd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [63:0]                     block_first_word_i,
  input  logic [63:0]                     block_second_word_i,
  input  logic [bctd_pkg::BPOS_W-1:0]     block_column_i,
  input  logic [bctd_pkg::BPOS_W-1:0]     block_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bctd_pkg::PIX_W-1:0]      pixel_x_o,
  output logic [bctd_pkg::PIX_W-1:0]      pixel_y_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic                            last_texel_o
);

  logic [bctd_pkg::FMT_W-1:0] fmt_q;
  logic [bctd_pkg::DIM_W-1:0] width_q, height_q;
  logic                       adv;
  logic                       slot_valid;
  bctd_pkg::texel_t           slot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= bctd_pkg::RESET_FORMAT;
      width_q <= bctd_pkg::RESET_WIDTH;
      height_q <= bctd_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bctd_pkg::CFG_FORMAT: fmt_q <= cfg_data_i[bctd_pkg::FMT_W-1:0];
        bctd_pkg::CFG_WIDTH: width_q <= cfg_data_i[bctd_pkg::DIM_W-1:0];
        bctd_pkg::CFG_HEIGHT: height_q <= cfg_data_i[bctd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  bctd_seq #(
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .block_first_word_i (block_first_word_i),
    .block_second_word_i(block_second_word_i),
    .block_column_i     (block_column_i),
    .block_row_i        (block_row_i),
    .fmt_i              (fmt_q),
    .width_i            (width_q),
    .height_i           (height_q),
    .adv_i              (adv),
    .slot_valid_o       (slot_valid),
    .slot_o             (slot)
  );

  bctd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_valid_i(slot_valid),
    .slot_i      (slot),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .last_texel_o(last_texel_o)
  );

endmodule

// File: tb/sv/tb_bc_texture_block_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BC1-BC5 block decoder: texel predictor, random flow control.
module tb_bc_texture_block_decoder;

  localparam int          CLK_PERIOD  = 20;
  localparam int unsigned MAX_SIDE    = bctd_pkg::DEFAULT_MAX_SIDE;
  localparam int          PIPE_SETTLE = 12;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          LONG_HOLD   = 300;

  localparam logic [bctd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [bctd_pkg::FMT_W-1:0]     FMT_BAD_LO     = 3'd5;
  localparam logic [bctd_pkg::FMT_W-1:0]     FMT_BAD_HI     = 3'd7;

  typedef struct {
    logic [13:0] x;
    logic [13:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } texel_rec_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [14:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] block_first_word_i;
  logic [63:0] block_second_word_i;
  logic [11:0] block_column_i;
  logic [11:0] block_row_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [13:0] pixel_x_o;
  logic [13:0] pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        last_texel_o;

  // Predictor copy of the configuration registers
  logic [2:0]  cur_format;
  logic [14:0] img_width;
  logic [14:0] img_height;

  texel_rec_t  pending_texels[$];
  int          error_count;
  int          cycle_count;
  int          burst_left;
  bit          hold_off_req;

  bc_texture_block_decoder #(
    .MAX_IMAGE_SIDE(MAX_SIDE)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .block_first_word_i(block_first_word_i),
    .block_second_word_i(block_second_word_i),
    .block_column_i(block_column_i),
    .block_row_i(block_row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_x_o(pixel_x_o),
    .pixel_y_o(pixel_y_o),
    .red_o(red_o),
    .green_o(green_o),
    .blue_o(blue_o),
    .alpha_o(alpha_o),
    .last_texel_o(last_texel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // 8-entry alpha ramp
  function automatic logic [7:0] ramp_level(input logic [63:0] word, input int unsigned n);
    int unsigned a0;
    int unsigned a1;
    int unsigned k;
    a0 = 32'(word[7:0]);
    a1 = 32'(word[15:8]);
    k  = 32'((word >> (16 + 3 * n)) & 64'h7);
    if (k == 0) return a0[7:0];
    if (k == 1) return a1[7:0];
    if (a0 > a1) return 8'(((8 - k) * a0 + (k - 1) * a1) / 7);
    if (k >= 6) return (k == 6) ? 8'd0 : 8'd255;
    return 8'(((6 - k) * a0 + (k - 1) * a1) / 5);
  endfunction

  // RGB565 colour block; three-colour mode only where allowed and c0 <= c1
  function automatic rgb_t color_level(input logic [63:0] word, input int unsigned n,
                                       input bit allow_three);
    int unsigned c0;
    int unsigned c1;
    int unsigned idx;
    int unsigned v;
    int unsigned e0[3];
    int unsigned e1[3];
    logic [7:0]  ch[3];
    rgb_t        res;
    c0 = 32'(word[15:0]);
    c1 = 32'(word[31:16]);
    idx = 32'((word >> (32 + 2 * n)) & 64'h3);
    e0[0] = ((c0 >> 11) & 'h1F) << 3;
    e0[1] = ((c0 >> 5) & 'h3F) << 2;
    e0[2] = (c0 & 'h1F) << 3;
    e1[0] = ((c1 >> 11) & 'h1F) << 3;
    e1[1] = ((c1 >> 5) & 'h3F) << 2;
    e1[2] = (c1 & 'h1F) << 3;
    for (int i = 0; i < 3; i++) begin
      if (idx == 0) v = e0[i];
      else if (idx == 1) v = e1[i];
      else if (c0 > c1 || !allow_three) begin
        v = (idx == 2) ? (2 * e0[i] + e1[i] + 1) / 3 : (e0[i] + 2 * e1[i] + 1) / 3;
      end else begin
        v = (idx == 2) ? (e0[i] + e1[i] + 1) >> 1 : 0;
      end
      ch[i] = v[7:0];
    end
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    return res;
  endfunction

  // Queue the in-image texels of one block in row order, last one flagged
  function automatic void decode_block_texels(input logic [63:0] w0, input logic [63:0] w1,
                                              input logic [11:0] col, input logic [11:0] row);
    int unsigned bx;
    int unsigned by;
    int unsigned wlim;
    int unsigned hlim;
    int unsigned px;
    int unsigned py;
    rgb_t        rgb;
    texel_rec_t  t;
    texel_rec_t  prev;
    bit          have_prev;
    bx = col * 4;
    by = row * 4;
    wlim = (img_width < MAX_SIDE) ? img_width : MAX_SIDE;
    hlim = (img_height < MAX_SIDE) ? img_height : MAX_SIDE;
    have_prev = 1'b0;
    if (cur_format > bctd_pkg::FMT_BC5) return;
    for (int unsigned n = 0; n < 16; n++) begin
      px = bx + (n & 3);
      py = by + (n >> 2);
      if (px >= wlim || py >= hlim) continue;
      t.x = 14'(px);
      t.y = 14'(py);
      t.r = 8'd0;
      t.g = 8'd0;
      t.b = 8'd0;
      t.a = 8'd255;
      t.last = 1'b0;
      case (cur_format)
        bctd_pkg::FMT_BC1: begin
          rgb = color_level(w0, n, 1'b1);
          t.r = rgb.r;
          t.g = rgb.g;
          t.b = rgb.b;
        end
        bctd_pkg::FMT_BC2: begin
          rgb = color_level(w1, n, 1'b0);
          t.r = rgb.r;
          t.g = rgb.g;
          t.b = rgb.b;
          t.a = 8'(((w0 >> (4 * n)) & 64'hF) * 17);
        end
        bctd_pkg::FMT_BC3: begin
          rgb = color_level(w1, n, 1'b0);
          t.r = rgb.r;
          t.g = rgb.g;
          t.b = rgb.b;
          t.a = ramp_level(w0, n);
        end
        bctd_pkg::FMT_BC4: begin
          t.r = ramp_level(w0, n);
        end
        default: begin
          t.r = ramp_level(w1, n);
          t.g = ramp_level(w0, n);
        end
      endcase
      if (have_prev) pending_texels.push_back(prev);
      prev = t;
      have_prev = 1'b1;
    end
    if (have_prev) begin
      prev.last = 1'b1;
      pending_texels.push_back(prev);
    end
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : texel_check
    texel_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_texels.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected texel, expected none, actual x=%0d y=%0d",
                 $time, pixel_x_o, pixel_y_o);
      end else begin
        want = pending_texels.pop_front();
        check_field("pixel_x", 32'(want.x), 32'(pixel_x_o));
        check_field("pixel_y", 32'(want.y), 32'(pixel_y_o));
        check_field("red", 32'(want.r), 32'(red_o));
        check_field("green", 32'(want.g), 32'(green_o));
        check_field("blue", 32'(want.b), 32'(blue_o));
        check_field("alpha", 32'(want.a), 32'(alpha_o));
        check_field("last_texel", 32'(want.last), 32'(last_texel_o));
      end
    end
  end

  // Output stall: random modes, no-stall stretches, and a long hold-off on request
  initial begin : stall_pattern
    int stall_mode;
    int stall_run;
    out_stall_i = 1'b0;
    stall_run = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_mode = $urandom_range(2, 0);
          stall_run = $urandom_range(80, 10);
        end
        stall_run--;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(99, 0) < 30);
          default: out_stall_i <= ($urandom_range(99, 0) < 75);
        endcase
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] ramp_word(input logic [7:0] a0, input logic [7:0] a1,
                                            input int unsigned shift);
    logic [63:0] w;
    w = {48'd0, a1, a0};
    for (int unsigned n = 0; n < 16; n++) w[16 + 3 * n +: 3] = 3'((n + shift) % 8);
    return w;
  endfunction

  // Called and returns at a falling edge; valid stays high within a burst
  task automatic send_block(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [11:0] col, input logic [11:0] row);
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
    end
    in_valid_i <= 1'b1;
    block_first_word_i <= w0;
    block_second_word_i <= w1;
    block_column_i <= col;
    block_row_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_block_texels(w0, w1, col, row);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Stop sending and wait for every expected texel, then let the pipeline settle
  task automatic drain_texels();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_texels.size() != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [14:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bctd_pkg::CFG_FORMAT: cur_format = data[2:0];
      bctd_pkg::CFG_WIDTH:  img_width = data;
      bctd_pkg::CFG_HEIGHT: img_height = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [2:0] fmt, input int unsigned w, input int unsigned h);
    cfg_write(bctd_pkg::CFG_FORMAT, 15'(fmt));
    cfg_write(bctd_pkg::CFG_WIDTH, 15'(w));
    cfg_write(bctd_pkg::CFG_HEIGHT, 15'(h));
  endtask

  // BC1 in the 4x4 reset image
  task automatic test_reset_values();
    send_block(64'd0, rand64(), 12'd0, 12'd0);
    send_block({64{1'b1}}, rand64(), 12'd0, 12'd0);
    send_block({32'hE4E4E4E4, 16'h1234, 16'hF81F}, 64'd0, 12'd0, 12'd0);
    send_block({32'hE4E4E4E4, 16'hFFE0, 16'h07FF}, 64'd0, 12'd0, 12'd0);
    send_block(rand64(), rand64(), 12'd1, 12'd0);
    drain_texels();
  endtask

  // BC2 to BC5 with endpoint orderings and full index / code sweeps
  task automatic test_format_modes();
    configure(bctd_pkg::FMT_BC2, 16, 16);
    send_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 12'd0, 12'd0);
    send_block(64'd0, {64{1'b1}}, 12'd1, 12'd1);
    drain_texels();
    configure(bctd_pkg::FMT_BC3, 16, 16);
    send_block(ramp_word(8'd200, 8'd10, 0), {32'h1B1B1B1B, 16'h07FF, 16'h001F}, 12'd0, 12'd0);
    send_block(ramp_word(8'd10, 8'd200, 3), {32'hE4E4E4E4, 16'hF800, 16'h07E0}, 12'd2, 12'd3);
    send_block(ramp_word(8'd255, 8'd255, 5), rand64(), 12'd3, 12'd2);
    drain_texels();
    configure(bctd_pkg::FMT_BC4, 16, 16);
    send_block(ramp_word(8'd255, 8'd0, 0), rand64(), 12'd0, 12'd0);
    send_block(ramp_word(8'd0, 8'd255, 2), rand64(), 12'd1, 12'd0);
    send_block({64{1'b1}}, 64'd0, 12'd0, 12'd1);
    drain_texels();
    configure(bctd_pkg::FMT_BC5, 16, 16);
    send_block(ramp_word(8'd180, 8'd20, 1), ramp_word(8'd20, 8'd180, 4), 12'd0, 12'd0);
    send_block(ramp_word(8'd0, 8'd0, 7), ramp_word(8'd255, 8'd1, 6), 12'd3, 12'd3);
    drain_texels();
  endtask

  // Partial blocks at the image border, size clamps, unused index and unknown formats
  task automatic test_image_edges();
    configure(bctd_pkg::FMT_BC1, 6, 5);
    send_block(rand64(), rand64(), 12'd1, 12'd1);
    send_block(rand64(), rand64(), 12'd0, 12'd0);
    send_block(rand64(), rand64(), 12'd1, 12'd0);
    drain_texels();
    cfg_write(bctd_pkg::CFG_WIDTH, 15'd0);
    send_block(rand64(), rand64(), 12'd0, 12'd0);
    drain_texels();
    configure(bctd_pkg::FMT_BC3, 32767, 16384);
    send_block(rand64(), rand64(), 12'hFFF, 12'hFFF);
    send_block(rand64(), rand64(), 12'd0, 12'hFFF);
    drain_texels();
    cfg_write(CFG_UNUSED_IDX, 15'h7FFF);
    send_block(rand64(), rand64(), 12'd1, 12'd2);
    drain_texels();
    cfg_write(bctd_pkg::CFG_FORMAT, 15'(FMT_BAD_LO));
    send_block(rand64(), rand64(), 12'd0, 12'd0);
    drain_texels();
    cfg_write(bctd_pkg::CFG_FORMAT, 15'(FMT_BAD_HI));
    send_block(rand64(), rand64(), 12'd0, 12'd0);
    drain_texels();
    configure(bctd_pkg::FMT_BC5, 1, 1);
    send_block(rand64(), rand64(), 12'd0, 12'd0);
    drain_texels();
  endtask

  // Random blocks over several formats and image sizes
  task automatic test_random_blocks();
    int unsigned w;
    int unsigned h;
    bit          full_grid;
    logic [11:0] col;
    logic [11:0] row;
    for (int p = 0; p < 9; p++) begin
      full_grid = (p == 6 || p == 8);
      if (p == 6) begin
        w = MAX_SIDE;
        h = MAX_SIDE;
      end else if (p == 8) begin
        w = $urandom_range(32767, MAX_SIDE + 1);
        h = $urandom_range(32767, MAX_SIDE + 1);
      end else begin
        w = $urandom_range(40, 1);
        h = $urandom_range(40, 1);
      end
      configure(3'(p % 5), w, h);
      for (int i = 0; i < 31; i++) begin
        if (full_grid || $urandom_range(9, 0) == 0) begin
          col = 12'($urandom_range(4095, 0));
          row = 12'($urandom_range(4095, 0));
        end else begin
          // one past the last block column / row lands wholly outside
          col = 12'($urandom_range((w + 3) / 4, 0));
          row = 12'($urandom_range((h + 3) / 4, 0));
        end
        send_block(rand64(), rand64(), col, row);
      end
      drain_texels();
    end
  endtask

  // Hold the output off while blocks keep coming, so the input stalls
  task automatic test_backpressure();
    configure(bctd_pkg::FMT_BC3, 64, 64);
    hold_off_req = 1'b1;
    burst_left = 100;
    for (int i = 0; i < 24; i++)
      send_block(rand64(), rand64(), 12'($urandom_range(15, 0)), 12'($urandom_range(15, 0)));
    drain_texels();
  endtask

  initial begin
    error_count = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    cur_format = bctd_pkg::RESET_FORMAT;
    img_width = bctd_pkg::RESET_WIDTH;
    img_height = bctd_pkg::RESET_HEIGHT;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    block_first_word_i = '0;
    block_second_word_i = '0;
    block_column_i = '0;
    block_row_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_format_modes();
    test_image_edges();
    test_random_blocks();
    test_backpressure();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
